@@ design/ltsc_pkg.sv @@
// Shared types and constants for the LFSR table stream cipher.
// Used by the controller, the datapath and the top level; no dependencies.
package ltsc_pkg;

	localparam int unsigned FILL_ROUNDS_DEF = 10;
	localparam int unsigned ROUND_W = 4;

	localparam logic [31:0] STIR_SEED_XOR = 32'h49A5_F3C7;
	localparam logic [7:0] TABLE_INIT_XOR = 8'hAB;

	// Stir register taps, XORed with the round number.
	localparam logic [4:0] STIR_TAP_A = 5'd1;
	localparam logic [4:0] STIR_TAP_B = 5'd15;
	localparam logic [4:0] STIR_TAP_C = 5'd29;

	// Item functions.
	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_WORD = 2'd1;
	localparam logic [1:0] FN_BYTE = 2'd2;

	// Table write sources.
	localparam logic [2:0] W_NONE = 3'd0;
	localparam logic [2:0] W_FILL = 3'd1;
	localparam logic [2:0] W_STIR = 3'd2;
	localparam logic [2:0] W_LO = 3'd3;
	localparam logic [2:0] W_HI = 3'd4;

	// Table read addresses.
	localparam logic [2:0] R_NONE = 3'd0;
	localparam logic [2:0] R_STIR = 3'd1;
	localparam logic [2:0] R_NEW = 3'd2;
	localparam logic [2:0] R_HI = 3'd3;
	localparam logic [2:0] R_KS = 3'd4;

	typedef struct packed {
		logic ld_in;
		logic ld_key;
		logic sh_step;
		logic lf_step;
		logic mix_fin;
		logic acc_clr;
		logic acc_en;
		logic out_ld;
		logic [2:0] wsel;
		logic [2:0] rsel;
		logic [7:0] idx;
		logic [ROUND_W-1:0] round;
		logic [1:0] kbyte;
	} ctrl_cmd_t;

endpackage

@@ design/ltsc_ctrl.sv @@
// Sequencer for the stream cipher: table fill, table stirring, encrypt clocks
// and result hand-off. Depends on ltsc_pkg; drives ltsc_dpath by a command struct.
module ltsc_ctrl #(
	parameter int unsigned FILL_ROUNDS = ltsc_pkg::FILL_ROUNDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             func,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ltsc_pkg::ctrl_cmd_t    cmd
);
	import ltsc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FILL  = 4'd1;
	localparam logic [3:0] S_STIR  = 4'd2;
	localparam logic [3:0] S_STIRW = 4'd3;
	localparam logic [3:0] S_LA    = 4'd4;
	localparam logic [3:0] S_LB    = 4'd5;
	localparam logic [3:0] S_FLUSH = 4'd6;
	localparam logic [3:0] S_RDK   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	localparam logic [ROUND_W-1:0] ROUNDS_INIT = ROUND_W'(FILL_ROUNDS);

	logic [3:0] state_q, state_d;
	logic [7:0] idx_q, idx_d;
	logic [4:0] bit_q, bit_d;
	logic [ROUND_W-1:0] round_q, round_d;
	logic [1:0] kb_q, kb_d;
	logic [1:0] func_q, func_d;
	logic out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		bit_d = bit_q;
		round_d = round_q;
		kb_d = kb_q;
		func_d = func_q;
		out_valid_d = out_valid_q && out_stall;
		cmd = '0;
		cmd.wsel = W_NONE;
		cmd.rsel = R_NONE;
		cmd.idx = idx_q;
		cmd.round = round_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					func_d = func;
					idx_d = '0;
					bit_d = '0;
					case (func)
						FN_START: begin
							cmd.ld_key = 1'b1;
							state_d = S_FILL;
						end
						FN_WORD, FN_BYTE: state_d = S_LA;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_FILL: begin
				cmd.wsel = W_FILL;
				idx_d = idx_q + 8'd1;
				if (idx_q == 8'hFF) begin
					round_d = ROUNDS_INIT;
					state_d = S_STIR;
				end
			end
			S_STIR: begin
				cmd.sh_step = 1'b1;
				// The entry is fetched once at the start; the read data holds until written back.
				if (bit_q == 5'd0) begin
					cmd.rsel = R_STIR;
				end
				bit_d = bit_q + 5'd1;
				if (bit_q == 5'd31) begin
					state_d = S_STIRW;
				end
			end
			S_STIRW: begin
				cmd.wsel = W_STIR;
				idx_d = idx_q + 8'd1;
				state_d = S_STIR;
				if (idx_q == 8'hFF) begin
					if (round_q == ROUND_W'(1)) begin
						state_d = S_OUT;
					end else begin
						round_d = round_q - ROUND_W'(1);
					end
				end
			end
			S_LA: begin
				// Retire the upper update of the previous clock while fetching the lower entry.
				cmd.lf_step = 1'b1;
				cmd.rsel = R_NEW;
				if (bit_q != 5'd0) begin
					cmd.wsel = W_HI;
				end
				state_d = S_LB;
			end
			S_LB: begin
				cmd.wsel = W_LO;
				cmd.rsel = R_HI;
				bit_d = bit_q + 5'd1;
				state_d = (bit_q == 5'd31) ? S_FLUSH : S_LA;
			end
			S_FLUSH: begin
				cmd.wsel = W_HI;
				cmd.rsel = R_KS;
				cmd.acc_clr = 1'b1;
				cmd.kbyte = 2'd0;
				kb_d = 2'd0;
				state_d = S_RDK;
			end
			S_RDK: begin
				cmd.acc_en = 1'b1;
				if (func_q == FN_BYTE || kb_q == 2'd3) begin
					state_d = S_FIN;
				end else begin
					cmd.rsel = R_KS;
					cmd.kbyte = kb_q + 2'd1;
					kb_d = kb_q + 2'd1;
				end
			end
			S_FIN: begin
				cmd.mix_fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			bit_q <= '0;
			round_q <= '0;
			kb_q <= '0;
			func_q <= FN_START;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			bit_q <= bit_d;
			round_q <= round_d;
			kb_q <= kb_d;
			func_q <= func_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ design/ltsc_dpath.sv @@
// Datapath of the stream cipher: key, LFSR, mixer, stir register, mask table
// memory and output register. Depends on ltsc_pkg; steered by ltsc_ctrl.
module ltsc_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  ltsc_pkg::ctrl_cmd_t cmd,
	input  logic                key_we,
	input  logic [31:0]         key_wdata,
	input  logic [1:0]          func,
	input  logic [31:0]         plain_value,
	output logic [31:0]         cipher_value
);
	import ltsc_pkg::*;

	logic [31:0] key_q;
	logic [31:0] lfsr_q;
	logic [31:0] mixer_q;
	logic [31:0] sh_q;
	logic [31:0] ks_q;
	logic [31:0] plain_q;
	logic [1:0] func_q;
	logic [7:0] acc_q;
	logic [31:0] cipher_q;

	logic [7:0] mem [256];
	logic [7:0] rd_q;
	logic [7:0] wd_q;
	logic byp_q;
	logic [7:0] rdata;

	logic we, re;
	logic [7:0] wa, wd, ra;
	logic [4:0] ta, tb, tc;
	logic sh_bit, lf_bit;
	logic [31:0] sh_next, lf_next;
	logic [31:0] m0, m1, m_new, p_in, res;

	assign rdata = byp_q ? wd_q : rd_q;

	// Stir register taps move with the round number.
	assign ta = {1'b0, cmd.round} ^ STIR_TAP_A;
	assign tb = {1'b0, cmd.round} ^ STIR_TAP_B;
	assign tc = {1'b0, cmd.round} ^ STIR_TAP_C;
	assign sh_bit = sh_q[ta] ^ sh_q[tb] ^ sh_q[tc];
	assign sh_next = {sh_q[30:0], sh_bit};

	assign lf_bit = (func_q == FN_BYTE) ? (lfsr_q[9] ^ lfsr_q[20] ^ lfsr_q[31])
		: (lfsr_q[6] ^ lfsr_q[28] ^ lfsr_q[30]);
	assign lf_next = {lfsr_q[30:0], lf_bit};

	always_comb begin
		we = 1'b1;
		wa = cmd.idx;
		wd = cmd.idx ^ TABLE_INIT_XOR;
		case (cmd.wsel)
			W_FILL: begin
				wa = cmd.idx;
				wd = cmd.idx ^ TABLE_INIT_XOR;
			end
			W_STIR: begin
				wa = cmd.idx;
				wd = rdata ^ sh_q[7:0];
			end
			W_LO: begin
				wa = lfsr_q[7:0];
				wd = rdata ^ lfsr_q[15:8];
			end
			W_HI: begin
				wa = lfsr_q[23:16];
				wd = rdata ^ lfsr_q[31:24];
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		re = 1'b1;
		ra = cmd.idx;
		case (cmd.rsel)
			R_STIR: ra = cmd.idx;
			R_NEW: ra = lf_next[7:0];
			R_HI: ra = lfsr_q[23:16];
			R_KS: ra = ks_q[{cmd.kbyte, 3'b000} +: 8];
			default: re = 1'b0;
		endcase
	end

	// A read that hits the entry written in the same cycle returns the new byte.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
			byp_q <= we && (wa == ra);
			wd_q <= wd;
		end
	end

	always_comb begin
		if (func_q == FN_BYTE) begin
			m0 = mixer_q ^ (mixer_q >> 7);
			m1 = m0 ^ (m0 << 17);
			m_new = m1 ^ (m1 >> 21);
			p_in = {24'd0, plain_q[7:0]};
		end else begin
			m0 = mixer_q ^ (mixer_q >> 7);
			m1 = m0 ^ (m0 >> 21);
			m_new = m1 ^ (m1 << 17);
			p_in = plain_q;
		end
	end

	always_comb begin
		case (func_q)
			FN_WORD: res = plain_q ^ ks_q ^ {24'd0, acc_q};
			FN_BYTE: res = {24'd0, plain_q[7:0] ^ ks_q[7:0] ^ acc_q};
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			lfsr_q <= '0;
			mixer_q <= '0;
		end else begin
			if (key_we) begin
				key_q <= key_wdata;
			end
			if (cmd.ld_key) begin
				lfsr_q <= key_q;
				mixer_q <= key_q;
			end else if (cmd.lf_step) begin
				lfsr_q <= lf_next;
				mixer_q <= mixer_q ^ lf_next;
			end else if (cmd.mix_fin) begin
				lfsr_q <= lfsr_q ^ m_new ^ p_in;
				mixer_q <= m_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			plain_q <= plain_value;
			func_q <= func;
			ks_q <= '0;
		end else if (cmd.lf_step) begin
			ks_q <= ks_q ^ lf_next;
		end
		if (cmd.ld_key) begin
			sh_q <= key_q ^ STIR_SEED_XOR;
		end else if (cmd.sh_step) begin
			sh_q <= sh_next;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q | rdata;
		end
		if (cmd.out_ld) begin
			cipher_q <= res;
		end
	end

	assign cipher_value = cipher_q;

endmodule

@@ design/lfsr_table_stream_cipher.sv @@
// Data word: LFSR steps with table updates, key-stream byte reads and a final mix, then the
// result is registered; literal byte: likewise, one key-stream byte read; unused func: zero result.
// Start: table fill, then FILL_ROUNDS stir rounds. No beat is taken until the result is registered.
// The pace is set by the single-write table: two read-modify-writes per LFSR step.
// A waiting result does not block the next beat. Reset clears key, LFSR and mixer;
// the mask table is undefined until the first start item.
module lfsr_table_stream_cipher #(
	parameter int unsigned FILL_ROUNDS = ltsc_pkg::FILL_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cipher_key,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] plain_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] cipher_value
);
	import ltsc_pkg::*;

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ltsc_ctrl #(
		.FILL_ROUNDS(FILL_ROUNDS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd)
	);

	ltsc_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.key_we(cfg_valid && cfg_ready),
		.key_wdata(cipher_key),
		.func(func),
		.plain_value(plain_value),
		.cipher_value(cipher_value)
	);

	// An accepted beat keeps the block busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// A result appears only out of a busy sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

	// The output register is loaded only when it is free or being drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !out_valid || !out_stall)
		else $error("result overwritten while stalled");

endmodule
